// File: rtl/pwsd_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width symbol decoder package
// Shared types, register indexes and reset values for the time-code decoder.
// ----------------------------------------------------------------------------
package pwsd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_WINDOW_ZERO  = 3'd0;
   localparam logic [2:0] REG_WINDOW_ONE   = 3'd1;
   localparam logic [2:0] REG_WINDOW_TWO   = 3'd2;
   localparam logic [2:0] REG_WINDOW_THREE = 3'd3;
   localparam logic [2:0] REG_SYNC_GAP     = 3'd4;
   localparam logic [2:0] REG_FRAME_LENGTH = 3'd5;

   // Register reset values.
   localparam logic [31:0] RST_WINDOW_ZERO  = 32'd215616690;
   localparam logic [31:0] RST_WINDOW_ONE   = 32'd431233410;
   localparam logic [31:0] RST_WINDOW_TWO   = 32'd645539410;
   localparam logic [31:0] RST_WINDOW_THREE = 32'd860500760;
   localparam logic [15:0] RST_SYNC_GAP     = 16'd32768;
   localparam logic [4:0]  RST_FRAME_LENGTH = 5'd21;

   // Symbol code of a sync mark.
   localparam logic [2:0] SYM_SYNC = 3'd4;

   // Line edge event or rearm request.
   localparam logic FUNC_EDGE  = 1'b0;
   localparam logic FUNC_REARM = 1'b1;

   // Pulse timing phase.
   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_LOW  = 2'd1,
      PH_HIGH = 2'd2
   } phase_type;

   // Configuration as seen by the decoder.
   typedef struct packed {
      logic [3:0][31:0] windows;
      logic [15:0]      sync_gap;
      logic [4:0]       frame_length;
   } cfg_type;

   // One decoded result item.
   typedef struct packed {
      logic [2:0] symbol;
      logic [4:0] position;
      logic       frame_done;
      logic [4:0] sync_position;
   } result_type;

endpackage

// File: rtl/pulse_width_symbol_decoder_top.sv
// ----------------------------------------------------------------------------
// Pulse-width symbol decoder
// Decodes time-code symbols from line edge events.
// ----------------------------------------------------------------------------
// Usage:
// Each req_ item is either a line edge (req_func low) with the new level and
// the tick count since the previous edge, or a rearm (req_func high). A low
// pulse is matched against four windows to give data symbols 0 to 3; a long
// high gap ending in a falling edge gives sync symbol 4. Each symbol leaves
// on the rsp_ channel with its frame position, the frame-done flag and the
// position of the last sync. After a completed frame edges are ignored until
// a rearm item arrives.
// Timing: an item is registered on acceptance and decoded from the input
// register; when the result slot is free, a result that carries a symbol is
// loaded into the result register and shown on rsp_. One item is accepted
// every cycle while req_stall is low. When rsp_stall holds a pending
// result, the input register holds its item and req_stall rises until the
// result slot drains. Reset clears the channels and the decode state
// (disarmed) and loads the default register values. Registers are to be
// written through csr_ only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module pulse_width_symbol_decoder_top #(
   parameter int MAX_FRAME = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic        req_level,
   input  logic [15:0] req_interval,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_symbol,
   output logic [4:0]  rsp_position,
   output logic        rsp_frame_done,
   output logic [4:0]  rsp_sync_position,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   pwsd_pkg::cfg_type    cfg;
   pwsd_pkg::result_type result;
   pwsd_pkg::result_type rsp_data;
   logic                 push;
   logic                 out_free;

   // Configuration registers.
   pwsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register and decode.
   pwsd_core #(
      .MAX_FRAME (MAX_FRAME)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_level    (req_level),
      .req_interval (req_interval),
      .cfg          (cfg),
      .out_free     (out_free),
      .push         (push),
      .result       (result)
   );

   // Result register.
   pwsd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_symbol        = rsp_data.symbol;
   assign rsp_position      = rsp_data.position;
   assign rsp_frame_done    = rsp_data.frame_done;
   assign rsp_sync_position = rsp_data.sync_position;

endmodule

// File: rtl/pwsd_csr.sv
// ----------------------------------------------------------------------------
// Pulse-width symbol decoder configuration registers
// Holds the four low-width windows, the sync gap and the frame length.
// ----------------------------------------------------------------------------
module pwsd_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output pwsd_pkg::cfg_type cfg
);

   pwsd_pkg::cfg_type cfg_ff;
   pwsd_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pwsd_pkg::REG_WINDOW_ZERO:  cfg_in.windows[0]   = csr_wdata;
            pwsd_pkg::REG_WINDOW_ONE:   cfg_in.windows[1]   = csr_wdata;
            pwsd_pkg::REG_WINDOW_TWO:   cfg_in.windows[2]   = csr_wdata;
            pwsd_pkg::REG_WINDOW_THREE: cfg_in.windows[3]   = csr_wdata;
            pwsd_pkg::REG_SYNC_GAP:     cfg_in.sync_gap     = csr_wdata[15:0];
            pwsd_pkg::REG_FRAME_LENGTH: cfg_in.frame_length = csr_wdata[4:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.windows[0]   <= pwsd_pkg::RST_WINDOW_ZERO;
         cfg_ff.windows[1]   <= pwsd_pkg::RST_WINDOW_ONE;
         cfg_ff.windows[2]   <= pwsd_pkg::RST_WINDOW_TWO;
         cfg_ff.windows[3]   <= pwsd_pkg::RST_WINDOW_THREE;
         cfg_ff.sync_gap     <= pwsd_pkg::RST_SYNC_GAP;
         cfg_ff.frame_length <= pwsd_pkg::RST_FRAME_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/pwsd_core.sv
// ----------------------------------------------------------------------------
// Pulse-width symbol decoder core
// Input register, decode state and the single-pass symbol decode logic.
// ----------------------------------------------------------------------------
module pwsd_core #(
   parameter int MAX_FRAME = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic                 req_level,
   input  logic [15:0]          req_interval,
   input  pwsd_pkg::cfg_type    cfg,
   input  logic                 out_free,
   output logic                 push,
   output pwsd_pkg::result_type result
);

   localparam logic [4:0] MaxLength = 5'(MAX_FRAME);

   // Input register.
   logic        in_valid_ff;
   logic        in_func_ff;
   logic        in_level_ff;
   logic [15:0] in_interval_ff;

   // Decode state.
   pwsd_pkg::phase_type phase_ff, phase_in;
   logic [4:0]          count_ff, count_in;
   logic [4:0]          sync_ff, sync_in;
   logic                armed_ff, armed_in;

   logic       consume;
   logic       hit;
   logic [2:0] sym;
   logic [3:0] in_win;
   logic [4:0] eff_length;
   logic [4:0] count_inc;
   logic       done;

   // An item leaves the input register once the result slot can take it.
   assign consume   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign push      = consume && hit;

   // Window matches: strictly inside both bounds.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         in_win[i] = (in_interval_ff > cfg.windows[i][15:0]) &&
                     (in_interval_ff < cfg.windows[i][31:16]);
      end
   end

   // Clamp the frame length to one through the largest frame.
   always_comb begin
      if (cfg.frame_length == 5'd0) begin
         eff_length = 5'd1;
      end else if (cfg.frame_length > MaxLength) begin
         eff_length = MaxLength;
      end else begin
         eff_length = cfg.frame_length;
      end
   end

   assign count_inc = count_ff + 5'd1;
   assign done      = count_inc >= eff_length;

   // Next state and result for the item in the input register.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sync_in  = sync_ff;
      armed_in = armed_ff;
      hit      = 1'b0;
      sym      = 3'd0;
      if (in_func_ff == pwsd_pkg::FUNC_REARM) begin
         armed_in = 1'b1;
         phase_in = pwsd_pkg::PH_WAIT;
         count_in = 5'd0;
         sync_in  = 5'd0;
      end else if (armed_ff) begin
         case (phase_ff)
            pwsd_pkg::PH_WAIT: begin
               if (!in_level_ff) begin
                  phase_in = pwsd_pkg::PH_LOW;
               end
            end
            pwsd_pkg::PH_LOW: begin
               if (in_level_ff) begin
                  phase_in = pwsd_pkg::PH_HIGH;
                  hit      = |in_win;
                  if (in_win[0]) begin
                     sym = 3'd0;
                  end else if (in_win[1]) begin
                     sym = 3'd1;
                  end else if (in_win[2]) begin
                     sym = 3'd2;
                  end else begin
                     sym = 3'd3;
                  end
               end
            end
            pwsd_pkg::PH_HIGH: begin
               if (!in_level_ff) begin
                  phase_in = pwsd_pkg::PH_LOW;
                  if (in_interval_ff > cfg.sync_gap) begin
                     hit     = 1'b1;
                     sym     = pwsd_pkg::SYM_SYNC;
                     sync_in = count_ff;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
         // Symbol bookkeeping and end of frame.
         if (hit) begin
            count_in = count_inc;
            if (done) begin
               armed_in = 1'b0;
               phase_in = pwsd_pkg::PH_WAIT;
               count_in = 5'd0;
            end
         end
      end
   end

   assign result.symbol        = sym;
   assign result.position      = count_ff;
   assign result.frame_done    = done;
   assign result.sync_position = sync_in;

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Input payload.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_func_ff     <= req_func;
         in_level_ff    <= req_level;
         in_interval_ff <= req_interval;
      end
   end

   // State update once per consumed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pwsd_pkg::PH_WAIT;
         count_ff <= 5'd0;
         sync_ff  <= 5'd0;
         armed_ff <= 1'b0;
      end else if (consume) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sync_ff  <= sync_in;
         armed_ff <= armed_in;
      end
   end

   // A completed frame disarms the decoder.
   assert property (@(posedge clock) disable iff (reset)
      push && result.frame_done |=> !armed_ff)
      else $error("armed after frame done");

   // A sync symbol records its own position.
   assert property (@(posedge clock) disable iff (reset)
      push && result.symbol == pwsd_pkg::SYM_SYNC |-> result.sync_position == result.position)
      else $error("sync position mismatch");

   // Nothing is decoded while disarmed.
   assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> !push)
      else $error("result while disarmed");

   // A rearm item restarts progress.
   assert property (@(posedge clock) disable iff (reset)
      consume && in_func_ff == pwsd_pkg::FUNC_REARM |=> armed_ff && count_ff == 5'd0)
      else $error("rearm did not restart");

endmodule

// File: rtl/pwsd_out_stage.sv
// ----------------------------------------------------------------------------
// Pulse-width symbol decoder output stage
// Result register that holds one item until the receiver takes it.
// ----------------------------------------------------------------------------
module pwsd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pwsd_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pwsd_pkg::result_type rsp_data
);

   logic                 valid_ff;
   pwsd_pkg::result_type data_ff;

   // The slot is free when empty or when its item leaves this cycle.
   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= result;
      end
   end

endmodule
